/* sv/cat_pkg.sv */
package cat_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_SETUP,
		ST_EMIT,
		ST_ROT1,
		ST_ROT2
	} cat_state_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic setup;
		logic emit;
		logic rot_mul;
		logic rot_sum;
	} cat_cmd_t;

	typedef struct packed {
		logic drawable;
		logic sqrt_done;
		logic out_busy;
		logic emit_last;
		logic need_rotate;
	} cat_status_t;

	localparam logic [1:0] RING_CENTER = 2'd0;
	localparam logic [1:0] RING_INNER  = 2'd1;
	localparam logic [1:0] RING_OUTER  = 2'd2;

	function automatic logic signed [17:0] cos_rom(input logic [4:0] n);
		case (n)
			5'd3: cos_rom = -18'sd32768;
			5'd4: cos_rom = 18'sd0;
			5'd5: cos_rom = 18'sd20252;
			5'd6: cos_rom = 18'sd32768;
			5'd7: cos_rom = 18'sd40861;
			5'd8: cos_rom = 18'sd46341;
			5'd9: cos_rom = 18'sd50203;
			5'd10: cos_rom = 18'sd53020;
			5'd11: cos_rom = 18'sd55132;
			5'd12: cos_rom = 18'sd56756;
			5'd13: cos_rom = 18'sd58029;
			5'd14: cos_rom = 18'sd59046;
			5'd15: cos_rom = 18'sd59870;
			5'd16: cos_rom = 18'sd60547;
			5'd17: cos_rom = 18'sd61111;
			5'd18: cos_rom = 18'sd61584;
			5'd19: cos_rom = 18'sd61985;
			5'd20: cos_rom = 18'sd62328;
			5'd21: cos_rom = 18'sd62624;
			5'd22: cos_rom = 18'sd62881;
			5'd23: cos_rom = 18'sd63106;
			5'd24: cos_rom = 18'sd63303;
			5'd25: cos_rom = 18'sd63477;
			5'd26: cos_rom = 18'sd63632;
			5'd27: cos_rom = 18'sd63769;
			5'd28: cos_rom = 18'sd63893;
			5'd29: cos_rom = 18'sd64004;
			5'd30: cos_rom = 18'sd64104;
			5'd31: cos_rom = 18'sd64194;
			default: cos_rom = 18'sd0;
		endcase
	endfunction

	function automatic logic signed [17:0] sin_rom(input logic [4:0] n);
		case (n)
			5'd3: sin_rom = 18'sd56756;
			5'd4: sin_rom = 18'sd65536;
			5'd5: sin_rom = 18'sd62328;
			5'd6: sin_rom = 18'sd56756;
			5'd7: sin_rom = 18'sd51238;
			5'd8: sin_rom = 18'sd46341;
			5'd9: sin_rom = 18'sd42126;
			5'd10: sin_rom = 18'sd38521;
			5'd11: sin_rom = 18'sd35431;
			5'd12: sin_rom = 18'sd32768;
			5'd13: sin_rom = 18'sd30456;
			5'd14: sin_rom = 18'sd28435;
			5'd15: sin_rom = 18'sd26656;
			5'd16: sin_rom = 18'sd25080;
			5'd17: sin_rom = 18'sd23674;
			5'd18: sin_rom = 18'sd22415;
			5'd19: sin_rom = 18'sd21280;
			5'd20: sin_rom = 18'sd20252;
			5'd21: sin_rom = 18'sd19317;
			5'd22: sin_rom = 18'sd18464;
			5'd23: sin_rom = 18'sd17681;
			5'd24: sin_rom = 18'sd16962;
			5'd25: sin_rom = 18'sd16298;
			5'd26: sin_rom = 18'sd15684;
			5'd27: sin_rom = 18'sd15114;
			5'd28: sin_rom = 18'sd14583;
			5'd29: sin_rom = 18'sd14088;
			5'd30: sin_rom = 18'sd13626;
			5'd31: sin_rom = 18'sd13192;
			default: sin_rom = 18'sd0;
		endcase
	endfunction

endpackage

/* sv/cat_ctrl.sv */
module cat_ctrl
	import cat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cat_status_t status,
	output cat_cmd_t    cmd
);

	cat_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.drawable) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (status.sqrt_done) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!status.out_busy) begin
					if (status.emit_last) state_d = ST_IDLE;
					else if (status.need_rotate) state_d = ST_ROT1;
				end
			end
			ST_ROT1: state_d = ST_ROT2;
			ST_ROT2: state_d = ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQRT: cmd.sqrt_step = 1'b1;
			ST_SETUP: cmd.setup = 1'b1;
			ST_EMIT: cmd.emit = !status.out_busy;
			ST_ROT1: cmd.rot_mul = 1'b1;
			ST_ROT2: cmd.rot_sum = 1'b1;
			default: cmd = '0;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_rot_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT1 |=> state_q == ST_ROT2) else $error("rotation split");
	a_setup_from_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |-> $past(state_q) == ST_SQRT) else $error("bad setup entry");

endmodule

/* sv/cat_datapath.sv */
module cat_datapath
	import cat_pkg::*;
#(
	parameter int MAX_SEGMENTS = 31,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [15:0]            radius,
	input  logic signed [15:0]            inner_radius,
	input  logic        [4:0]             segment_request,
	input  cat_cmd_t                      cmd,
	output cat_status_t                   status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] vertex_x,
	output logic signed [COORD_WIDTH-1:0] vertex_y,
	output logic        [1:0]             ring,
	output logic                          strip_mode,
	output logic                          last
);

	localparam logic [4:0] MAX_SEG = 5'(MAX_SEGMENTS);
	localparam logic signed [COORD_WIDTH+16:0] CHI = (COORD_WIDTH+17)'((1 << (COORD_WIDTH-1)) - 1);
	localparam logic signed [COORD_WIDTH+16:0] CLO = -CHI - 1;

	logic signed [COORD_WIDTH-1:0] cx_q, cy_q;
	logic signed [15:0] r0_q, r1_q;
	logic [4:0]  req_q, seg_q, idx_q;
	logic        strip_q, half_q;
	logic [19:0] rem_q;
	logic [10:0] root_q;
	logic [3:0]  sq_cnt_q;
	logic signed [31:0] ox_q, oy_q, ix_q, iy_q;
	logic signed [17:0] c_q, s_q;
	logic signed [31:0] fx_q, fy_q;
	// products of the rotation, one pair of rings
	logic signed [49:0] p_cx_q, p_sy_q, p_sx_q, p_cy_q;
	logic signed [49:0] q_cx_q, q_sy_q, q_sx_q, q_cy_q;
	logic v_q, first_q;

	// restoring square root, two bits a cycle
	logic [12:0] sq_cmp;
	logic        sq_ge;
	logic [4:0]  auto_seg, seg_sel;

	assign sq_cmp = {root_q, 2'b01};

	// operand bits consumed from the top of a shift register
	logic [19:0] sq_src_q;
	logic [13:0] sq_part;
	logic [13:0] sq_diff;
	assign sq_part = {rem_q[11:0], sq_src_q[19:18]};
	assign sq_diff = sq_part - {1'b0, sq_cmp};
	assign sq_ge = !sq_diff[13];

	always_comb begin
		auto_seg = (root_q > 11'(MAX_SEGMENTS)) ? MAX_SEG :
			(root_q < 11'd3) ? 5'd3 : root_q[4:0];
		seg_sel = (req_q < 5'd3) ? auto_seg : (req_q > MAX_SEG ? MAX_SEG : req_q);
	end

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sh07FFFFFFF) sat32 = 32'sh7FFFFFFF;
		else if (v < -35'sh080000000) sat32 = -32'sh80000000;
		else sat32 = v[31:0];
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] cout(
		input logic signed [COORD_WIDTH-1:0] c, input logic signed [31:0] p);
		logic signed [COORD_WIDTH+16:0] v;
		v = (COORD_WIDTH+17)'(c) + (COORD_WIDTH+17)'($signed(p[31:16]));
		if (v > CHI) cout = CHI[COORD_WIDTH-1:0];
		else if (v < CLO) cout = CLO[COORD_WIDTH-1:0];
		else cout = v[COORD_WIDTH-1:0];
	endfunction

	logic signed [15:0] r_min, r_max;
	logic [18:0] r25;
	assign r_min = (radius < inner_radius) ? radius : inner_radius;
	assign r_max = (radius < inner_radius) ? inner_radius : radius;
	assign r25 = 19'(({5'b0, r_max[14:0]} * 20'd25) >> 2);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= center_x;
			cy_q <= center_y;
			r0_q <= r_min;
			r1_q <= r_max;
			req_q <= segment_request;
			sq_src_q <= {1'b0, r25};
			rem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			sq_src_q <= {sq_src_q[17:0], 2'b00};
			if (sq_ge) begin
				rem_q <= {6'b0, sq_diff};
				root_q <= {root_q[9:0], 1'b1};
			end else begin
				rem_q <= {6'b0, sq_part};
				root_q <= {root_q[9:0], 1'b0};
			end
		end
		if (cmd.setup) begin
			seg_q <= seg_sel;
			c_q <= cos_rom(seg_sel);
			s_q <= sin_rom(seg_sel);
			strip_q <= r0_q > 16'sd0;
			ox_q <= {r1_q, 16'h0};
			oy_q <= '0;
			ix_q <= (r0_q > 16'sd0) ? {r0_q, 16'h0} : 32'sd0;
			iy_q <= '0;
			fx_q <= {r1_q, 16'h0};
			fy_q <= '0;
		end
		if (cmd.rot_mul) begin
			p_cx_q <= c_q * ox_q;
			p_sy_q <= s_q * oy_q;
			p_sx_q <= s_q * ox_q;
			p_cy_q <= c_q * oy_q;
			q_cx_q <= c_q * ix_q;
			q_sy_q <= s_q * iy_q;
			q_sx_q <= s_q * ix_q;
			q_cy_q <= c_q * iy_q;
		end
		if (cmd.rot_sum) begin
			ox_q <= sat32(35'(p_cx_q >>> 16) - 35'(p_sy_q >>> 16));
			oy_q <= sat32(35'(p_sx_q >>> 16) + 35'(p_cy_q >>> 16));
			ix_q <= sat32(35'(q_cx_q >>> 16) - 35'(q_sy_q >>> 16));
			iy_q <= sat32(35'(q_sx_q >>> 16) + 35'(q_cy_q >>> 16));
		end
		if (cmd.emit) begin
			if (strip_q) begin
				vertex_x <= cout(cx_q, half_q ? ox_q : ix_q);
				vertex_y <= cout(cy_q, half_q ? oy_q : iy_q);
				ring <= half_q ? RING_OUTER : RING_INNER;
				last <= half_q && idx_q == seg_q;
			end else if (first_q) begin
				vertex_x <= cx_q;
				vertex_y <= cy_q;
				ring <= RING_CENTER;
				last <= 1'b0;
			end else begin
				vertex_x <= cout(cx_q, idx_q == seg_q ? fx_q : ox_q);
				vertex_y <= cout(cy_q, idx_q == seg_q ? fy_q : oy_q);
				ring <= RING_OUTER;
				last <= idx_q == seg_q;
			end
			strip_mode <= strip_q;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
			sq_cnt_q <= '0;
			idx_q <= '0;
			half_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) v_q <= 1'b0;
			if (cmd.load) sq_cnt_q <= '0;
			if (cmd.sqrt_step) sq_cnt_q <= sq_cnt_q + 4'd1;
			if (cmd.setup) begin
				idx_q <= '0;
				half_q <= 1'b0;
				first_q <= 1'b1;
			end
			if (cmd.emit) begin
				v_q <= 1'b1;
				if (strip_q) begin
					half_q <= !half_q;
					if (half_q) idx_q <= idx_q + 5'd1;
				end else if (first_q) begin
					first_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
		end
	end

	always_comb begin
		status.drawable = radius > 16'sd0;
		status.sqrt_done = sq_cnt_q == 4'd9;
		status.out_busy = v_q && !out_ready;
		if (strip_q) begin
			status.emit_last = half_q && idx_q == seg_q;
			status.need_rotate = half_q;
		end else begin
			status.emit_last = !first_q && idx_q == seg_q;
			status.need_rotate = !first_q;
		end
	end

	assign out_valid = v_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_x)) else $error("output dropped");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && !out_ready)) else $error("emit over pending vertex");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 5'(MAX_SEGMENTS)) else $error("index overrun");

endmodule

/* sv/circle_annulus_tessellator_core.sv */
// channel | signals                                         | direction
// input   | in_valid in_ready center_x center_y radius       | in
//         | inner_radius segment_request                    |
// output  | out_valid out_ready vertex_x vertex_y ring        | out
//         | strip_mode last                                 |
// a circle is accepted, then the square root runs and a setup step follows;
// each vertex then takes an emit step, held while the output stalls, and each
// rim step adds a rotation multiply step and a rotation sum step
// non-positive radius is accepted with no output
// arst_n clears controller and output valid; output stalls hold the emitter
module circle_annulus_tessellator_core
	import cat_pkg::*;
#(
	parameter int MAX_SEGMENTS = 31,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [15:0]            radius,
	input  logic signed [15:0]            inner_radius,
	input  logic        [4:0]             segment_request,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] vertex_x,
	output logic signed [COORD_WIDTH-1:0] vertex_y,
	output logic        [1:0]             ring,
	output logic                          strip_mode,
	output logic                          last
);

	cat_cmd_t    cmd;
	cat_status_t status;

	cat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	cat_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .center_x(center_x), .center_y(center_y),
		.radius(radius), .inner_radius(inner_radius), .segment_request(segment_request),
		.cmd(cmd), .status(status), .out_valid(out_valid), .out_ready(out_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .ring(ring), .strip_mode(strip_mode),
		.last(last)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import cat_pkg::*;

	localparam int MAX_SEG = 31;
	localparam int CW = 16;
	localparam int HANG_LIMIT = 20000;

	typedef struct {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [15:0]   r;
		logic signed [15:0]   ri;
		logic [4:0]           req;
	} circle_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [1:0]           ring;
		logic                 strip;
		logic                 last;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] center_x = '0;
	logic signed [CW-1:0] center_y = '0;
	logic signed [15:0] radius = '0;
	logic signed [15:0] inner_radius = '0;
	logic [4:0] segment_request = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] vertex_x;
	logic signed [CW-1:0] vertex_y;
	logic [1:0] ring;
	logic strip_mode;
	logic last;

	circle_t pending_circles[$];
	vertex_t expected_vertices[$];
	int errors = 0;
	int circles_sent = 0;
	int vertices_seen = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit stim_done = 1'b0;

	// shadow of the rotation state
	logic signed [31:0] opx, opy, ipx, ipy;

	circle_annulus_tessellator_core #(.MAX_SEGMENTS(MAX_SEG), .COORD_WIDTH(CW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.center_x(center_x), .center_y(center_y), .radius(radius),
		.inner_radius(inner_radius), .segment_request(segment_request),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .ring(ring),
		.strip_mode(strip_mode), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_q16(longint v);
		return v >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [CW-1:0] place(logic signed [CW-1:0] c,
			logic signed [31:0] p);
		longint v;
		longint hi;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		v = longint'(c) + floor_q16(longint'(p));
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return v[CW-1:0];
	endfunction

	function automatic int int_sqrt(int unsigned v);
		int unsigned root;
		int unsigned b;
		root = 0;
		b = 32'h40000000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else
				root = root >> 1;
			b = b >> 2;
		end
		return root;
	endfunction

	// rotation factors of 2*pi/n in Q1.16, rounded
	function automatic void trig_for(int n, output longint c, output longint s);
		real a;
		a = 6.283185307179586 / n;
		c = longint'($floor($cos(a) * 65536.0 + 0.5));
		s = longint'($floor($sin(a) * 65536.0 + 0.5));
	endfunction

	task automatic spin(inout logic signed [31:0] x, inout logic signed [31:0] y,
			input longint c, input longint s);
		longint ox;
		longint oy;
		ox = x;
		oy = y;
		x = clamp32(floor_q16(c * ox) - floor_q16(s * oy));
		y = clamp32(floor_q16(s * ox) + floor_q16(c * oy));
	endtask

	task automatic push_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic [1:0] rg, logic st, logic lst);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.ring = rg;
		v.strip = st;
		v.last = lst;
		expected_vertices.push_back(v);
	endtask

	task automatic tessellate(circle_t t);
		longint r0, r1, c, s;
		int seg;
		logic signed [CW-1:0] fx, fy;
		if (t.r <= 0) return;
		r0 = (t.r < t.ri) ? t.r : t.ri;
		r1 = (t.r < t.ri) ? t.ri : t.r;
		if (t.req < 3) begin
			seg = int_sqrt(int'((25 * r1) / 4));
			if (seg < 3) seg = 3;
		end else
			seg = t.req;
		if (seg > MAX_SEG) seg = MAX_SEG;
		trig_for(seg, c, s);
		opx = clamp32(r1 * 65536);
		opy = 0;
		if (r0 > 0) begin
			ipx = clamp32(r0 * 65536);
			ipy = 0;
			for (int i = 0; i <= seg; i++) begin
				push_vertex(place(t.cx, ipx), place(t.cy, ipy), RING_INNER, 1'b1, 1'b0);
				push_vertex(place(t.cx, opx), place(t.cy, opy), RING_OUTER, 1'b1, i == seg);
				spin(opx, opy, c, s);
				spin(ipx, ipy, c, s);
			end
		end else begin
			fx = place(t.cx, opx);
			fy = place(t.cy, opy);
			push_vertex(t.cx, t.cy, RING_CENTER, 1'b0, 1'b0);
			for (int i = 0; i < seg; i++) begin
				push_vertex(place(t.cx, opx), place(t.cy, opy), RING_OUTER, 1'b0, 1'b0);
				spin(opx, opy, c, s);
			end
			push_vertex(fx, fy, RING_OUTER, 1'b0, 1'b1);
		end
	endtask

	task automatic add_circle(int cx, int cy, int r, int ri, int req);
		circle_t t;
		t.cx = CW'(cx);
		t.cy = CW'(cy);
		t.r = 16'(r);
		t.ri = 16'(ri);
		t.req = 5'(req);
		pending_circles.push_back(t);
	endtask

	// random radius: mostly modest, sometimes full range
	function automatic int pick_radius();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 40) - 20;
			default: return $urandom_range(1, 3000);
		endcase
	endfunction

	initial begin
		add_circle(0, 0, 160, 0, 0);
		add_circle(0, 0, 0, 50, 5);
		add_circle(100, -100, -32768, 10, 8);
		add_circle(0, 0, 1, 0, 0);
		add_circle(0, 0, 32767, 0, 0);
		add_circle(32767, 32767, 32767, 32767, 31);
		add_circle(-32768, -32768, 32767, 1, 31);
		add_circle(-32768, 32767, 20000, -32768, 3);
		add_circle(500, 300, 400, 200, 4);
		add_circle(-500, 300, 100, 400, 12);
		add_circle(16, -16, 800, 800, 1);
		add_circle(0, 0, 1000, -5, 2);
		add_circle(1234, -4321, 255, 128, 31);
		add_circle(0, 0, 64, 0, 30);
		add_circle(7, 9, 3, 2, 6);
		add_circle(-1, -1, 10000, 9999, 7);
		for (int i = 0; i < 100; i++) begin
			if ($urandom_range(0, 3) == 0)
				add_circle($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
					pick_radius(), pick_radius(), $urandom_range(0, 31));
			else
				add_circle($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
					pick_radius(), $urandom_range(0, 2) == 0 ? 0 : pick_radius(),
					$urandom_range(0, 31));
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// quiet stretch with no idling on either side
	always @(posedge clk) begin
		if (circles_sent == 40) calm <= 1'b1;
		if (circles_sent == 60) calm <= 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid && pending_circles.size() != 0 &&
					(calm || $urandom_range(0, 99) >= 28)) begin
				circle_t t;
				t = pending_circles.pop_front();
				center_x <= t.cx;
				center_y <= t.cy;
				radius <= t.r;
				inner_radius <= t.ri;
				segment_request <= t.req;
				in_valid <= 1'b1;
				tessellate(t);
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 28);
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			circles_sent <= circles_sent + 1;
			in_valid <= 1'b0;
		end
		if (out_valid && out_ready) begin
			vertex_t e;
			vertices_seen <= vertices_seen + 1;
			if (expected_vertices.size() == 0) begin
				$error("vertex with no circle pending: x=%0d y=%0d", vertex_x, vertex_y);
				errors <= errors + 1;
			end else begin
				e = expected_vertices.pop_front();
				if (vertex_x !== e.x) begin
					$error("vertex_x expected %0d got %0d", e.x, vertex_x);
					errors <= errors + 1;
				end
				if (vertex_y !== e.y) begin
					$error("vertex_y expected %0d got %0d", e.y, vertex_y);
					errors <= errors + 1;
				end
				if (ring !== e.ring) begin
					$error("ring expected %0d got %0d", e.ring, ring);
					errors <= errors + 1;
				end
				if (strip_mode !== e.strip) begin
					$error("strip_mode expected %0d got %0d", e.strip, strip_mode);
					errors <= errors + 1;
				end
				if (last !== e.last) begin
					$error("last expected %0d got %0d", e.last, last);
					errors <= errors + 1;
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("watchdog expired with %0d vertices outstanding", expected_vertices.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		wait (pending_circles.size() == 0 && !in_valid);
		wait (expected_vertices.size() == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d circles, checked %0d vertices", circles_sent, vertices_seen);
		$display("fan, strip, automatic and clamped segment counts and saturated coordinates");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* circle_annulus_tessellator_core.f */
sv/cat_pkg.sv
sv/cat_ctrl.sv
sv/cat_datapath.sv
sv/circle_annulus_tessellator_core.sv
tb/sv/tb_top.sv
